/* hw/rtl/sgi_pkg.sv */
// Shared widths, types and helper functions of the segment intersection unit.
`default_nettype none
package sgi_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_W      = 32;

   // derived widths
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int NM_W    = CROSS_W + DIFF_W;
   localparam int QUO_W   = DIFF_W + FRAC_BITS;
   localparam int SUM_W   = COORD_BITS + FRAC_BITS + OUT_W + 2;

   // accept edge to result transfer edge
   localparam int LATENCY = QUO_W + 6;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_SHARED    = 2'd1,
      KIND_CROSS     = 2'd2,
      KIND_COLLINEAR = 2'd3
   } kind_type;

   typedef struct packed {
      coord_type a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
   } pair_type;

   // result info riding along the divider
   typedef struct packed {
      kind_type  kind;
      coord_type base_x;
      coord_type base_y;
      logic      neg_x;
      logic      neg_y;
   } side_type;

   typedef struct packed {
      logic [CROSS_W-1:0] rem_x;
      logic [QUO_W-1:0]   low_x;
      logic [CROSS_W-1:0] rem_y;
      logic [QUO_W-1:0]   low_y;
      logic [CROSS_W-1:0] dvs;
      side_type           side;
   } div_type;

   typedef struct packed {
      logic [CROSS_W-1:0] rem;
      logic [QUO_W-1:0]   low;
   } step_type;

   // one restoring division step: quotient bit enters low at the bottom
   function automatic step_type div_step(logic [CROSS_W-1:0] rem, logic [QUO_W-1:0] low,
                                         logic [CROSS_W-1:0] dvs);
      logic [CROSS_W:0] trial;
      logic [CROSS_W:0] sub;
      logic             qbit;
      step_type         res;
      trial = {rem, low[QUO_W-1]};
      sub   = trial - {1'b0, dvs};
      qbit  = (trial >= {1'b0, dvs});
      res.rem = qbit ? sub[CROSS_W-1:0] : trial[CROSS_W-1:0];
      res.low = {low[QUO_W-2:0], qbit};
      return res;
   endfunction

   // both strictly positive or both strictly negative
   function automatic logic same_sign(cross_type p, cross_type q);
      return (p > 0 && q > 0) || (p < 0 && q < 0);
   endfunction

   function automatic logic [CROSS_W-1:0] abs_cross(cross_type v);
      cross_type n;
      n = -v;
      return v[CROSS_W-1] ? n : v;
   endfunction

   function automatic logic [DIFF_W-1:0] abs_diff(diff_type v);
      diff_type n;
      n = -v;
      return v[DIFF_W-1] ? n : v;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/segment_intersection_unit.sv */
// Top level of the segment intersection unit.
//
// Usage: drive the eight endpoint coordinates of segments A and B on the req_
// ports and raise start; a pair transfers at every rising edge with start high
// and busy low. busy is high only during reset, so one pair can enter every
// cycle. Each pair gives exactly one result: rsp_valid is high for one cycle
// with rsp_hit_kind (none, shared endpoint, crossing, collinear overlap) and
// the point rsp_cross_x / rsp_cross_y in Q16.16 (zero unless shared endpoint
// or crossing).
// Path: a result passes five front stages, one divider stage per quotient bit,
// 33 here, and the output register; the package parameter LATENCY gives the
// delay. Throughput: one pair per cycle outside reset, set by the fully
// pipelined divider. Results leave in input order.
// Reset clears all valid bits; pairs in flight are dropped. The receiver
// cannot stall, so nothing holds the pipeline.
`default_nettype none
module segment_intersection_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire sgi_pkg::coord_type  req_a_start_x,
   input  wire sgi_pkg::coord_type  req_a_start_y,
   input  wire sgi_pkg::coord_type  req_a_end_x,
   input  wire sgi_pkg::coord_type  req_a_end_y,
   input  wire sgi_pkg::coord_type  req_b_start_x,
   input  wire sgi_pkg::coord_type  req_b_start_y,
   input  wire sgi_pkg::coord_type  req_b_end_x,
   input  wire sgi_pkg::coord_type  req_b_end_y,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_hit_kind,
   output logic signed [31:0]       rsp_cross_x,
   output logic signed [31:0]       rsp_cross_y
);
   import sgi_pkg::*;

   logic     accept;
   pair_type pair;
   logic     front_valid;
   div_type  front_div;
   logic     div_valid;
   div_type  div_out;

   logic                    rsp_valid_ff;
   kind_type                kind_ff;
   logic signed [OUT_W-1:0] x_ff, x_in;
   logic signed [OUT_W-1:0] y_ff, y_in;

   assign busy   = reset;
   assign accept = start && !busy;

   assign pair.a0x = req_a_start_x;
   assign pair.a0y = req_a_start_y;
   assign pair.a1x = req_a_end_x;
   assign pair.a1y = req_a_end_y;
   assign pair.b0x = req_b_start_x;
   assign pair.b0y = req_b_start_y;
   assign pair.b1x = req_b_end_x;
   assign pair.b1y = req_b_end_y;

   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pair   (pair),
      .out_valid (front_valid),
      .out_div   (front_div)
   );

   sgi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_div    (front_div),
      .out_valid (div_valid),
      .out_div   (div_out)
   );

   // base point in fixed point plus signed quotient
   always_comb begin
      logic signed [QUO_W:0]   off_x, off_y;
      logic signed [SUM_W-1:0] sum_x, sum_y;
      off_x = div_out.side.neg_x ? -$signed({1'b0, div_out.low_x})
                                 : $signed({1'b0, div_out.low_x});
      off_y = div_out.side.neg_y ? -$signed({1'b0, div_out.low_y})
                                 : $signed({1'b0, div_out.low_y});
      sum_x = (SUM_W'(div_out.side.base_x) <<< FRAC_BITS) + SUM_W'(off_x);
      sum_y = (SUM_W'(div_out.side.base_y) <<< FRAC_BITS) + SUM_W'(off_y);
      x_in = sum_x[OUT_W-1:0];
      y_in = sum_y[OUT_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= div_out.side.kind;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit_kind = kind_ff;
   assign rsp_cross_x  = x_ff;
   assign rsp_cross_y  = y_ff;

   // every transfer in gives a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("result missing after pipeline latency");

   // no point unless shared endpoint or crossing
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit_kind == KIND_NONE || rsp_hit_kind == KIND_COLLINEAR)
      |-> rsp_cross_x == 0 && rsp_cross_y == 0)
      else $error("point reported for a non-point result");

   // a result never appears without a transfer in at the right time
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(reset, LATENCY) |-> $past(accept, LATENCY))
      else $error("result without matching transfer");

endmodule
`default_nettype wire

/* hw/rtl/sgi_front.sv */
// Front pipeline: endpoint checks, cross products, classification, dividend build.
`default_nettype none
module sgi_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire sgi_pkg::pair_type in_pair,
   output logic                   out_valid,
   output sgi_pkg::div_type       out_div
);
   import sgi_pkg::*;

   typedef struct packed {
      diff_type  s1x, s1y, s2x, s2y, ex, ey, fx, fy, gx, gy, hx, hy;
      coord_type hp_x, hp_y, a0x, a0y;
      logic      pt_hit;
      logic      meet;
   } st1_type;

   typedef struct packed {
      prod_type  pa0, pa1, pb0, pb1, pc0, pc1, pd0, pd1, pe0, pe1;
      diff_type  s1x, s1y;
      coord_type hp_x, hp_y, a0x, a0y;
      logic      pt_hit;
      logic      meet;
   } st2_type;

   typedef struct packed {
      cross_type da0, da1, db0, db1, den;
      diff_type  s1x, s1y;
      coord_type hp_x, hp_y, a0x, a0y;
      logic      pt_hit;
      logic      meet;
   } st3_type;

   typedef struct packed {
      logic [CROSS_W-1:0] n;
      logic [CROSS_W-1:0] d;
      logic [DIFF_W-1:0]  mx;
      logic [DIFF_W-1:0]  my;
      side_type           side;
   } st4_type;

   logic    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   st1_type s1_ff, s1_in;
   st2_type s2_ff, s2_in;
   st3_type s3_ff, s3_in;
   st4_type s4_ff, s4_in;
   div_type s5_ff, s5_in;

   // stage 1: differences, shared endpoint, bounding boxes
   always_comb begin
      logic      b0_up;
      coord_type bu_x, bu_y, bl_x, bl_y;
      coord_type lo1, hi1, lo2, hi2, lo3, hi3, lo4, hi4;
      b0_up = (in_pair.b0y > in_pair.b1y) ||
              (in_pair.b0y == in_pair.b1y && in_pair.b0x > in_pair.b1x);
      bu_x = b0_up ? in_pair.b0x : in_pair.b1x;
      bu_y = b0_up ? in_pair.b0y : in_pair.b1y;
      bl_x = b0_up ? in_pair.b1x : in_pair.b0x;
      bl_y = b0_up ? in_pair.b1y : in_pair.b0y;
      s1_in.s1x = diff_type'(in_pair.a1x) - diff_type'(in_pair.a0x);
      s1_in.s1y = diff_type'(in_pair.a1y) - diff_type'(in_pair.a0y);
      s1_in.s2x = diff_type'(in_pair.b1x) - diff_type'(in_pair.b0x);
      s1_in.s2y = diff_type'(in_pair.b1y) - diff_type'(in_pair.b0y);
      s1_in.ex  = diff_type'(in_pair.b0x) - diff_type'(in_pair.a0x);
      s1_in.ey  = diff_type'(in_pair.b0y) - diff_type'(in_pair.a0y);
      s1_in.fx  = diff_type'(in_pair.b1x) - diff_type'(in_pair.a0x);
      s1_in.fy  = diff_type'(in_pair.b1y) - diff_type'(in_pair.a0y);
      s1_in.gx  = diff_type'(in_pair.a0x) - diff_type'(in_pair.b0x);
      s1_in.gy  = diff_type'(in_pair.a0y) - diff_type'(in_pair.b0y);
      s1_in.hx  = diff_type'(in_pair.a1x) - diff_type'(in_pair.b0x);
      s1_in.hy  = diff_type'(in_pair.a1y) - diff_type'(in_pair.b0y);
      s1_in.a0x = in_pair.a0x;
      s1_in.a0y = in_pair.a0y;
      if ((in_pair.a0x == bu_x && in_pair.a0y == bu_y) ||
          (in_pair.a1x == bu_x && in_pair.a1y == bu_y)) begin
         s1_in.pt_hit = 1'b1;
         s1_in.hp_x   = bu_x;
         s1_in.hp_y   = bu_y;
      end else begin
         s1_in.pt_hit = (in_pair.a0x == bl_x && in_pair.a0y == bl_y) ||
                        (in_pair.a1x == bl_x && in_pair.a1y == bl_y);
         s1_in.hp_x   = bl_x;
         s1_in.hp_y   = bl_y;
      end
      lo1 = (in_pair.a0x < in_pair.a1x) ? in_pair.a0x : in_pair.a1x;
      hi1 = (in_pair.a0x < in_pair.a1x) ? in_pair.a1x : in_pair.a0x;
      lo2 = (in_pair.b0x < in_pair.b1x) ? in_pair.b0x : in_pair.b1x;
      hi2 = (in_pair.b0x < in_pair.b1x) ? in_pair.b1x : in_pair.b0x;
      lo3 = (in_pair.a0y < in_pair.a1y) ? in_pair.a0y : in_pair.a1y;
      hi3 = (in_pair.a0y < in_pair.a1y) ? in_pair.a1y : in_pair.a0y;
      lo4 = (in_pair.b0y < in_pair.b1y) ? in_pair.b0y : in_pair.b1y;
      hi4 = (in_pair.b0y < in_pair.b1y) ? in_pair.b1y : in_pair.b0y;
      s1_in.meet = (lo1 <= hi2) && (lo2 <= hi1) && (lo3 <= hi4) && (lo4 <= hi3);
   end

   // stage 2: partial products of the cross products
   always_comb begin
      s2_in.pa0 = prod_type'(s1_ff.s1x) * prod_type'(s1_ff.ey);
      s2_in.pa1 = prod_type'(s1_ff.s1y) * prod_type'(s1_ff.ex);
      s2_in.pb0 = prod_type'(s1_ff.s1x) * prod_type'(s1_ff.fy);
      s2_in.pb1 = prod_type'(s1_ff.s1y) * prod_type'(s1_ff.fx);
      s2_in.pc0 = prod_type'(s1_ff.s2x) * prod_type'(s1_ff.gy);
      s2_in.pc1 = prod_type'(s1_ff.s2y) * prod_type'(s1_ff.gx);
      s2_in.pd0 = prod_type'(s1_ff.s2x) * prod_type'(s1_ff.hy);
      s2_in.pd1 = prod_type'(s1_ff.s2y) * prod_type'(s1_ff.hx);
      s2_in.pe0 = prod_type'(s1_ff.s1x) * prod_type'(s1_ff.s2y);
      s2_in.pe1 = prod_type'(s1_ff.s2x) * prod_type'(s1_ff.s1y);
      s2_in.s1x    = s1_ff.s1x;
      s2_in.s1y    = s1_ff.s1y;
      s2_in.hp_x   = s1_ff.hp_x;
      s2_in.hp_y   = s1_ff.hp_y;
      s2_in.a0x    = s1_ff.a0x;
      s2_in.a0y    = s1_ff.a0y;
      s2_in.pt_hit = s1_ff.pt_hit;
      s2_in.meet   = s1_ff.meet;
   end

   // stage 3: orientation values and denominator
   always_comb begin
      s3_in.da0 = cross_type'(s2_ff.pa0) - cross_type'(s2_ff.pa1);
      s3_in.da1 = cross_type'(s2_ff.pb0) - cross_type'(s2_ff.pb1);
      s3_in.db0 = cross_type'(s2_ff.pc0) - cross_type'(s2_ff.pc1);
      s3_in.db1 = cross_type'(s2_ff.pd0) - cross_type'(s2_ff.pd1);
      s3_in.den = cross_type'(s2_ff.pe0) - cross_type'(s2_ff.pe1);
      s3_in.s1x    = s2_ff.s1x;
      s3_in.s1y    = s2_ff.s1y;
      s3_in.hp_x   = s2_ff.hp_x;
      s3_in.hp_y   = s2_ff.hp_y;
      s3_in.a0x    = s2_ff.a0x;
      s3_in.a0y    = s2_ff.a0y;
      s3_in.pt_hit = s2_ff.pt_hit;
      s3_in.meet   = s2_ff.meet;
   end

   // stage 4: classify; non-crossing cases divide zero by one
   always_comb begin
      logic     miss;
      logic     all_zero;
      kind_type kind;
      miss = same_sign(s3_ff.da0, s3_ff.da1) || same_sign(s3_ff.db0, s3_ff.db1);
      all_zero = (s3_ff.da0 == 0) && (s3_ff.da1 == 0) &&
                 (s3_ff.db0 == 0) && (s3_ff.db1 == 0);
      priority if (s3_ff.pt_hit) begin
         kind = KIND_SHARED;
      end else if (miss) begin
         kind = KIND_NONE;
      end else if (all_zero) begin
         kind = s3_ff.meet ? KIND_COLLINEAR : KIND_NONE;
      end else begin
         kind = KIND_CROSS;
      end
      s4_in.side.kind  = kind;
      s4_in.side.neg_x = s3_ff.db0[CROSS_W-1] ^ s3_ff.s1x[DIFF_W-1] ^ s3_ff.den[CROSS_W-1];
      s4_in.side.neg_y = s3_ff.db0[CROSS_W-1] ^ s3_ff.s1y[DIFF_W-1] ^ s3_ff.den[CROSS_W-1];
      s4_in.mx = abs_diff(s3_ff.s1x);
      s4_in.my = abs_diff(s3_ff.s1y);
      unique case (kind)
         KIND_SHARED: begin
            s4_in.side.base_x = s3_ff.hp_x;
            s4_in.side.base_y = s3_ff.hp_y;
         end
         KIND_CROSS: begin
            s4_in.side.base_x = s3_ff.a0x;
            s4_in.side.base_y = s3_ff.a0y;
         end
         default: begin
            s4_in.side.base_x = '0;
            s4_in.side.base_y = '0;
         end
      endcase
      if (kind == KIND_CROSS && s3_ff.den != 0) begin
         s4_in.n = abs_cross(s3_ff.db0);
         s4_in.d = abs_cross(s3_ff.den);
      end else begin
         s4_in.n = '0;
         s4_in.d = CROSS_W'(1);
      end
   end

   // stage 5: scaled numerators, split into start remainder and low bits
   always_comb begin
      logic [NM_W-1:0] nm_x;
      logic [NM_W-1:0] nm_y;
      nm_x = NM_W'(s4_ff.n) * NM_W'(s4_ff.mx);
      nm_y = NM_W'(s4_ff.n) * NM_W'(s4_ff.my);
      s5_in.rem_x = nm_x[NM_W-1:DIFF_W];
      s5_in.low_x = QUO_W'(nm_x[DIFF_W-1:0]) << FRAC_BITS;
      s5_in.rem_y = nm_y[NM_W-1:DIFF_W];
      s5_in.low_y = QUO_W'(nm_y[DIFF_W-1:0]) << FRAC_BITS;
      s5_in.dvs   = s4_ff.d;
      s5_in.side  = s4_ff.side;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
   end

   assign out_valid = v5_ff;
   assign out_div   = s5_ff;

endmodule
`default_nettype wire

/* hw/rtl/sgi_divider.sv */
// Pipelined restoring divider: one quotient bit per stage for both coordinates.
`default_nettype none
module sgi_divider (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire sgi_pkg::div_type in_div,
   output logic                  out_valid,
   output sgi_pkg::div_type      out_div
);
   import sgi_pkg::*;

   logic    valid_ff [QUO_W];
   div_type stage_ff [QUO_W];
   div_type stage_in [QUO_W];

   // each stage takes the previous stage's word
   always_comb begin
      div_type  src;
      step_type sx, sy;
      for (int k = 0; k < QUO_W; k++) begin
         src = (k == 0) ? in_div : stage_ff[(k == 0) ? 0 : k - 1];
         sx = div_step(src.rem_x, src.low_x, src.dvs);
         sy = div_step(src.rem_y, src.low_y, src.dvs);
         stage_in[k]       = src;
         stage_in[k].rem_x = sx.rem;
         stage_in[k].low_x = sx.low;
         stage_in[k].rem_y = sy.rem;
         stage_in[k].low_y = sy.low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < QUO_W; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         stage_ff[k] <= stage_in[k];
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_div   = stage_ff[QUO_W-1];

endmodule
`default_nettype wire

/* test/tb_segment_intersection_unit.sv */
// Self-checking testbench of the segment intersection unit.
`default_nettype none
module tb_segment_intersection_unit;
   import sgi_pkg::*;

   typedef struct {
      kind_type kind;
      longint   px;
      longint   py;
   } hit_type;

   // expected hits in order; reports mismatches
   class hit_board;
      hit_type pending[$];
      int      errors;

      function void note_pair(longint a0x, longint a0y, longint a1x, longint a1y,
                              longint b0x, longint b0y, longint b1x, longint b1y);
         hit_type h;
         longint  da0, da1, db0, db1, s1x, s1y, s2x, s2y, num, den, ux, uy, lx, ly;
         bit      b0_up;
         h.kind = KIND_NONE;
         h.px = 0;
         h.py = 0;
         // shared endpoint, upper point of B first
         b0_up = (b0y > b1y) || (b0y == b1y && b0x > b1x);
         ux = b0_up ? b0x : b1x;
         uy = b0_up ? b0y : b1y;
         lx = b0_up ? b1x : b0x;
         ly = b0_up ? b1y : b0y;
         if ((a0x == ux && a0y == uy) || (a1x == ux && a1y == uy)) begin
            h.kind = KIND_SHARED;
            h.px = ux << FRAC_BITS;
            h.py = uy << FRAC_BITS;
         end else if ((a0x == lx && a0y == ly) || (a1x == lx && a1y == ly)) begin
            h.kind = KIND_SHARED;
            h.px = lx << FRAC_BITS;
            h.py = ly << FRAC_BITS;
         end else begin
            s1x = a1x - a0x;
            s1y = a1y - a0y;
            s2x = b1x - b0x;
            s2y = b1y - b0y;
            da0 = s1x * (b0y - a0y) - s1y * (b0x - a0x);
            da1 = s1x * (b1y - a0y) - s1y * (b1x - a0x);
            db0 = s2x * (a0y - b0y) - s2y * (a0x - b0x);
            db1 = s2x * (a1y - b0y) - s2y * (a1x - b0x);
            if ((da0 > 0 && da1 > 0) || (da0 < 0 && da1 < 0) ||
                (db0 > 0 && db1 > 0) || (db0 < 0 && db1 < 0)) begin
               h.kind = KIND_NONE;
            end else if (da0 == 0 && da1 == 0 && db0 == 0 && db1 == 0) begin
               if (overlap(a0x, a1x, b0x, b1x) && overlap(a0y, a1y, b0y, b1y))
                  h.kind = KIND_COLLINEAR;
            end else begin
               num = db0;
               den = s1x * s2y - s2x * s1y;
               h.kind = KIND_CROSS;
               h.px = (a0x << FRAC_BITS) + scaled(num, s1x, den);
               h.py = (a0y << FRAC_BITS) + scaled(num, s1y, den);
            end
         end
         pending.push_back(h);
      endfunction

      // trunc(num*m*2^FRAC_BITS/den); magnitudes stay well within 128 bits
      function longint scaled(longint num, longint m, longint den);
         logic signed [127:0] p;
         if (den == 0) return 0;
         p = 128'(num) * 128'(m);
         p = p <<< FRAC_BITS;
         return longint'(p / 128'(den));
      endfunction

      function bit overlap(longint a, longint b, longint c, longint d);
         longint lo1, hi1, lo2, hi2;
         lo1 = a < b ? a : b;
         hi1 = a < b ? b : a;
         lo2 = c < d ? c : d;
         hi2 = c < d ? d : c;
         return lo1 <= hi2 && lo2 <= hi1;
      endfunction

      function void check_hit(logic [1:0] kind, logic [31:0] x, logic [31:0] y);
         hit_type h;
         if (pending.size() == 0) begin
            report("result with no pair waiting");
            return;
         end
         h = pending.pop_front();
         if (kind !== h.kind)
            report($sformatf("kind %0d, expected %0d", kind, h.kind));
         if (x !== 32'(h.px))
            report($sformatf("cross_x %h, expected %h", x, 32'(h.px)));
         if (y !== 32'(h.py))
            report($sformatf("cross_y %h, expected %h", y, 32'(h.py)));
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 50) $display("mismatch: %s", msg);
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_valid;
   coord_type a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
   logic [1:0] rsp_hit_kind;
   logic signed [31:0] rsp_cross_x, rsp_cross_y;

   hit_board board;
   int idle_pct;
   int quiet;
   bit done;

   segment_intersection_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(a0x), .req_a_start_y(a0y), .req_a_end_x(a1x), .req_a_end_y(a1y),
      .req_b_start_x(b0x), .req_b_start_y(b0y), .req_b_end_x(b1x), .req_b_end_y(b1y),
      .rsp_valid(rsp_valid), .rsp_hit_kind(rsp_hit_kind),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // send one pair, with random idle cycles before it
   task automatic send_pair(coord_type p0x, coord_type p0y, coord_type p1x, coord_type p1y,
                            coord_type q0x, coord_type q0y, coord_type q1x, coord_type q1y);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      a0x <= p0x; a0y <= p0y; a1x <= p1x; a1y <= p1y;
      b0x <= q0x; b0y <= q0y; b1x <= q1x; b1y <= q1y;
      do @(posedge clock); while (busy);
      board.note_pair(p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y);
   endtask

   function automatic coord_type pick(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(2 * span) - span);
   endfunction

   // random pair: mixes wide, narrow and shaped cases
   task automatic random_pair();
      coord_type c[8];
      coord_type k;
      int span, mode;
      mode = $urandom_range(9);
      span = ($urandom_range(3) == 0) ? 0 : ($urandom_range(1) ? 8 : 300);
      foreach (c[i]) c[i] = pick(span);
      case (mode)
         0: begin
            c[4] = c[$urandom_range(1) * 2];
            c[5] = c[($urandom_range(1) * 2) | 1];
            c[4] = c[0]; c[5] = c[1];
         end
         1: begin
            c[6] = c[2]; c[7] = c[3];
         end
         2: begin
            // collinear along a shared direction
            k = pick(5);
            c[2] = coord_type'(c[0] + 16'sd6); c[3] = coord_type'(c[1] + 16'sd3);
            c[4] = coord_type'(c[0] + 16'sd2 * k); c[5] = coord_type'(c[1] + k);
            c[6] = coord_type'(c[4] + 16'sd4); c[7] = coord_type'(c[5] + 16'sd2);
         end
         3: begin
            c[3] = c[1]; c[7] = c[5]; c[5] = c[1];
         end
         4: begin
            c[2] = c[0]; c[3] = c[1];
         end
         default: ;
      endcase
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // check each result at the edge that ends its strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_hit(rsp_hit_kind, rsp_cross_x, rsp_cross_y);
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 5000 && !done) begin
         $display("tb: failure");
         $finish;
      end
   end

   localparam coord_type MX = 16'sh7fff;
   localparam coord_type MN = -16'sh8000;

   initial begin
      board = new();
      done = 0;
      quiet = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      {a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y} = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each kind and the special cases
      send_pair(MN, MN, MX, MX, MN, MX, MX, MN);
      send_pair(MX, MN, MN, MX, MN, MN, MX, MX);
      send_pair(0, 0, 4, 4, 4, 4, 9, 1);
      send_pair(0, 0, 4, 4, 9, 1, 0, 0);
      send_pair(0, 0, 4, 0, 0, 0, 4, 0);
      send_pair(0, 0, 4, 0, 2, 0, 8, 0);
      send_pair(0, 0, 4, 0, 5, 0, 8, 0);
      send_pair(3, 3, 3, 3, 3, 3, 3, 3);
      send_pair(3, 3, 3, 3, 4, 4, 4, 4);
      send_pair(2, 2, 2, 2, 0, 0, 4, 4);
      send_pair(0, 0, 4, 0, 2, 0, 2, 5);
      send_pair(0, 0, 3, 1, 1, 0, 2, 7);
      send_pair(0, 0, 3, 1, 1, 5, 2, 7);
      send_pair(MN, MN, MN, MX, MX, MN, MX, MX);
      send_pair(MN, 0, MX, 1, 0, MN, 1, MX);
      send_pair(MX, MX, MN, MN, MN, MN, MX, MX);
      send_pair(-5, 7, 11, -13, 7, 9, -3, -6);
      send_pair(0, 0, 0, 0, 0, 1, 0, 1);
      drain();

      // random phases under different idling
      for (int p = 0; p < 5; p++) begin
         idle_pct = (p == 1) ? 49 : (p == 3) ? 31 : 0;
         repeat (340) random_pair();
         if (p == 2) drain();
      end
      drain();
      done = 1;
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
